// ----- rtl/brmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brmt_pkg: shared types and constants
// Generator constants, request queue entry and state codes.
// ----------------------------------------------------------------------------
package brmt_pkg;

    localparam int unsigned TwN = 624;
    localparam int unsigned TwM = 397;
    localparam int unsigned IdxW = 10;
    localparam logic [31:0] SeedReset = 32'd5489;
    localparam logic [31:0] InitMul = 32'd1812433253;
    localparam logic [31:0] MatrixA = 32'h9908b0df;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW = 1;

    // classified request handed from front to back
    typedef struct packed {
        logic        draw;      // needs a generator word
        logic        bad;
        logic [31:0] lo;
        logic [31:0] span;      // hi - lo + 1, below 2^31
    } req_t;

    typedef enum logic [3:0] {
        ST_SEED,      // write seed chain into memory
        ST_SEED_MUL,
        ST_IDLE,
        ST_TW_RD0,    // twist: read word i
        ST_TW_RD1,    // read word i+1
        ST_TW_RD2,    // read word i+M
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- rtl/brmt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brmt_front: request classifier and queue
// Checks bounds, computes the span and holds requests for the back end.
// ----------------------------------------------------------------------------
module brmt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [31:0]       lo_bound,
    input  logic [31:0]       hi_bound,
    output logic              q_valid,
    output brmt_pkg::req_t    q_head,
    input  logic              q_take
);

    brmt_pkg::req_t           mem_reg [brmt_pkg::QDepth];
    logic [brmt_pkg::QPtrW:0] cnt_reg, cnt_next;
    logic [brmt_pkg::QPtrW-1:0] wr_reg, rd_reg;
    brmt_pkg::req_t           cls;
    logic signed [32:0]       lo_x, hi_x, diff;
    logic                     do_push, do_pop;

    always_comb
    begin
        lo_x = {lo_bound[31], lo_bound};
        hi_x = {hi_bound[31], hi_bound};
        diff = hi_x - lo_x;
        cls.lo = lo_bound;
        cls.span = diff[31:0] + 32'd1;
        // reversed or span of 2^31 or more (diff >= 2^31 - 1)
        cls.bad = diff[32] || (diff[31:0] >= 32'h7fffffff);
        cls.draw = !cls.bad && (diff[31:0] != 32'd0);
    end

    assign full = (cnt_reg == (brmt_pkg::QPtrW+1)'(brmt_pkg::QDepth));
    assign q_valid = (cnt_reg != '0);
    assign q_head = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop = q_take && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= cls;
    end

endmodule

// ----- rtl/brmt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brmt_back: twister engine and modulo unit
// Seeds and twists the state memory, draws words and reduces them.
// ----------------------------------------------------------------------------
module brmt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [31:0]       seed_wdata,
    input  logic              q_valid,
    input  brmt_pkg::req_t    q_head,
    output logic              q_take,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       value,
    output logic              bad_range
);

    logic [31:0] mt_mem [brmt_pkg::TwN];
    logic [31:0] rd_data_reg;
    logic [brmt_pkg::IdxW-1:0] rd_addr;
    logic        mem_we;
    logic [brmt_pkg::IdxW-1:0] wr_addr;
    logic [31:0] wr_data;

    brmt_pkg::state_t state_reg, state_next;
    logic [brmt_pkg::IdxW-1:0] idx_reg, idx_next;   // seed/twist index
    logic [brmt_pkg::IdxW:0]   pos_reg, pos_next;   // word position
    logic [31:0] prev_reg, prev_next;               // seeding chain
    logic [31:0] prod_reg;
    logic [31:0] w0_reg, w0_next, w1_reg, w1_next;
    logic [31:0] rem_reg, rem_next, quo_reg, quo_next;
    logic [5:0]  bit_reg, bit_next;
    logic [31:0] lo_reg, span_reg;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic        obad_reg, obad_next;
    logic [brmt_pkg::IdxW-1:0] ip1, ipm;
    logic [31:0] y, v, r_sh, r_sub;
    logic        take;

    assign empty = !ovalid_reg;
    assign value = oval_reg;
    assign bad_range = obad_reg;

    always_comb
    begin
        ip1 = (idx_reg == brmt_pkg::IdxW'(brmt_pkg::TwN - 1)) ? '0 : idx_reg + 1'b1;
        if ({1'b0, idx_reg} >= (brmt_pkg::IdxW+1)'(brmt_pkg::TwN - brmt_pkg::TwM))
            ipm = idx_reg - brmt_pkg::IdxW'(brmt_pkg::TwN - brmt_pkg::TwM);
        else
            ipm = idx_reg + brmt_pkg::IdxW'(brmt_pkg::TwM);
        y = {w0_reg[31], w1_reg[30:0]};
        v = rd_data_reg ^ (y >> 1) ^ (y[0] ? brmt_pkg::MatrixA : 32'd0);
        r_sh = {rem_reg[30:0], quo_reg[31]};
        r_sub = r_sh - span_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brmt_pkg::ST_SEED:
                if (idx_reg == brmt_pkg::IdxW'(brmt_pkg::TwN - 1))
                    state_next = brmt_pkg::ST_IDLE;
                else
                    state_next = brmt_pkg::ST_SEED_MUL;
            brmt_pkg::ST_SEED_MUL: state_next = brmt_pkg::ST_SEED;
            brmt_pkg::ST_IDLE:
                if (q_valid)
                begin
                    if (!q_head.draw)
                        state_next = brmt_pkg::ST_OUT;
                    else if (pos_reg >= (brmt_pkg::IdxW+1)'(brmt_pkg::TwN))
                        state_next = brmt_pkg::ST_TW_RD0;
                    else
                        state_next = brmt_pkg::ST_DRAW_RD;
                end
            brmt_pkg::ST_TW_RD0: state_next = brmt_pkg::ST_TW_RD1;
            brmt_pkg::ST_TW_RD1: state_next = brmt_pkg::ST_TW_RD2;
            brmt_pkg::ST_TW_RD2: state_next = brmt_pkg::ST_TW_WR;
            brmt_pkg::ST_TW_WR:
                if (idx_reg == brmt_pkg::IdxW'(brmt_pkg::TwN - 1))
                    state_next = brmt_pkg::ST_DRAW_RD;
                else
                    state_next = brmt_pkg::ST_TW_RD0;
            brmt_pkg::ST_DRAW_RD: state_next = brmt_pkg::ST_DRAW_WAIT;
            brmt_pkg::ST_DRAW_WAIT: state_next = brmt_pkg::ST_DIV;
            brmt_pkg::ST_DIV:
                if (bit_reg == 6'd31)
                    state_next = brmt_pkg::ST_OUT;
            // hold until the output register is free
            brmt_pkg::ST_OUT:
                if (!ovalid_reg || pop)
                    state_next = brmt_pkg::ST_IDLE;
            default: state_next = brmt_pkg::ST_IDLE;
        endcase
        if (seed_we)
            state_next = brmt_pkg::ST_SEED;
    end

    // outputs and datapath
    always_comb
    begin
        idx_next = idx_reg;
        pos_next = pos_reg;
        prev_next = prev_reg;
        w0_next = w0_reg;
        w1_next = w1_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        ovalid_next = ovalid_reg && !pop;
        oval_next = oval_reg;
        obad_next = obad_reg;
        mem_we = 1'b0;
        wr_addr = idx_reg;
        wr_data = prev_reg;
        rd_addr = idx_reg;
        take = 1'b0;
        case (state_reg)
            brmt_pkg::ST_SEED:
            begin
                mem_we = 1'b1;
                wr_data = prev_reg;
            end
            brmt_pkg::ST_SEED_MUL:
            begin
                idx_next = idx_reg + 1'b1;
                prev_next = prod_reg + 32'(idx_reg + 1'b1);
            end
            brmt_pkg::ST_IDLE:
                idx_next = '0;
            brmt_pkg::ST_TW_RD0: rd_addr = idx_reg;
            brmt_pkg::ST_TW_RD1:
            begin
                rd_addr = ip1;
                w0_next = rd_data_reg;
            end
            brmt_pkg::ST_TW_RD2:
            begin
                rd_addr = ipm;
                w1_next = rd_data_reg;
            end
            brmt_pkg::ST_TW_WR:
            begin
                mem_we = 1'b1;
                wr_data = v;
                idx_next = ip1;
                pos_next = '0;
            end
            brmt_pkg::ST_DRAW_RD:
                rd_addr = pos_reg[brmt_pkg::IdxW-1:0];
            brmt_pkg::ST_DRAW_WAIT:
            begin
                pos_next = pos_reg + 1'b1;
                quo_next = brmt_pkg::temper(rd_data_reg);
                rem_next = '0;
                bit_next = '0;
            end
            brmt_pkg::ST_DIV:
            begin
                // restoring remainder, one bit per cycle
                quo_next = {quo_reg[30:0], 1'b0};
                rem_next = (r_sh >= span_reg) ? r_sub : r_sh;
                bit_next = bit_reg + 1'b1;
            end
            brmt_pkg::ST_OUT:
                if (!ovalid_reg || pop)
                begin
                    take = 1'b1;
                    ovalid_next = 1'b1;
                    obad_next = q_head.bad;
                    if (q_head.bad)
                        oval_next = '0;
                    else if (q_head.draw)
                        oval_next = lo_reg + rem_reg;
                    else
                        oval_next = q_head.lo;
                end
            default: ;
        endcase
        if (seed_we)
        begin
            idx_next = '0;
            prev_next = seed_wdata;
            pos_next = (brmt_pkg::IdxW+1)'(brmt_pkg::TwN);
        end
    end

    assign q_take = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brmt_pkg::ST_SEED;
            idx_reg <= '0;
            pos_reg <= (brmt_pkg::IdxW+1)'(brmt_pkg::TwN);
            prev_reg <= brmt_pkg::SeedReset;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            prev_reg <= prev_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= brmt_pkg::InitMul * (prev_reg ^ (prev_reg >> 30));
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        oval_reg <= oval_next;
        obad_reg <= obad_next;
        lo_reg <= q_head.lo;
        span_reg <= q_head.span;
        if (mem_we)
            mt_mem[wr_addr] <= wr_data;
        rd_data_reg <= mt_mem[rd_addr];
    end

endmodule

// ----- rtl/bounded_random_mt19937.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_random_mt19937: bounded random integers from MT19937
// Queue-style request/result block over a 624-word Mersenne Twister.
// ----------------------------------------------------------------------------
// A request with equal bounds or a rejected range skips the generator and
// the remainder unit. A drawing request passes through the remainder unit,
// which yields one bit per cycle; every 624th draw first runs a full twist
// over the state memory, stepping each word through ST_TW_RD0, ST_TW_RD1,
// ST_TW_RD2 and ST_TW_WR. After reset and after each seed write the block
// writes the seed chain into the state memory; requests queue meanwhile. A
// two-entry queue separates the request classifier from the generator.
module bounded_random_mt19937 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] lo_bound,
    input  logic [31:0] hi_bound,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] value,
    output logic        bad_range,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata
);

    logic           q_valid;
    logic           q_take;
    brmt_pkg::req_t q_head;

    brmt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .lo_bound (lo_bound),
        .hi_bound (hi_bound),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_take   (q_take)
    );

    brmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_take     (q_take),
        .empty      (empty),
        .pop        (pop),
        .value      (value),
        .bad_range  (bad_range)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for bounded_random_mt19937
// Drives bounded requests through the queue ports, predicts each value with
// an MT19937 model of its own and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CycleLimit = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] lo_bound = '0;
    logic [31:0] hi_bound = '0;
    logic        pop = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] seed_wdata = '0;
    logic        full;
    logic        empty;
    logic [31:0] value;
    logic        bad_range;

    typedef struct packed {
        logic [31:0] value;
        logic        bad;
    } outcome_t;

    logic [31:0] mt_words [brmt_pkg::TwN];
    int unsigned mt_pos;
    outcome_t    pending_q [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    int unsigned seeds_used = 0;
    bit          quiet = 1'b0;

    bounded_random_mt19937 uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .lo_bound(lo_bound), .hi_bound(hi_bound), .empty(empty), .pop(pop),
        .value(value), .bad_range(bad_range),
        .seed_we(seed_we), .seed_wdata(seed_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void mt_seed(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < brmt_pkg::TwN; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = brmt_pkg::InitMul * (p ^ (p >> 30)) + i;
        end
        mt_pos = brmt_pkg::TwN;
    endfunction

    function automatic logic [31:0] mt_next();
        logic [31:0] y;
        logic [31:0] v;
        if (mt_pos >= brmt_pkg::TwN)
        begin
            for (int i = 0; i < brmt_pkg::TwN; i++)
            begin
                y = (mt_words[i] & 32'h80000000) |
                    (mt_words[(i+1) % brmt_pkg::TwN] & 32'h7fffffff);
                v = mt_words[(i + brmt_pkg::TwM) % brmt_pkg::TwN] ^ (y >> 1);
                if (y[0])
                    v = v ^ brmt_pkg::MatrixA;
                mt_words[i] = v;
            end
            mt_pos = 0;
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic outcome_t predict_value(input logic [31:0] lo, input logic [31:0] hi);
        outcome_t r;
        longint   slo;
        longint   shi;
        longint   span;
        logic [31:0] w;
        slo = longint'($signed(lo));
        shi = longint'($signed(hi));
        r.value = '0;
        r.bad = 1'b1;
        if (shi >= slo)
        begin
            span = shi - slo + 1;
            if (span < 64'h80000000)
            begin
                r.bad = 1'b0;
                if (span == 1)
                    r.value = lo;
                else
                begin
                    w = mt_next();
                    r.value = lo + (w % span[31:0]);
                end
            end
        end
        return r;
    endfunction

    // result side: random pop stalls, check every accepted item
    initial
    begin
        int gap;
        outcome_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                results_seen++;
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: value %h bad %b", value, bad_range);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (want.value !== value || want.bad !== bad_range)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %h bad %b, got %h %b",
                                     want.value, want.bad, value, bad_range);
                    end
                end
            end
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 19);
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                // account for an item popped on the last stall edge: none, pop low
            end
            pop <= 1'b1;
        end
    end

    // push stays high after acceptance; the next item takes it over, an idle gap or a drain drops it
    task automatic send_request(input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        lo_bound <= lo;
        hi_bound <= hi;
        do
            @(posedge clk);
        while (full);
        pending_q = {pending_q, predict_value(lo, hi)};
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        wait_drained();
        seed_we <= 1'b1;
        seed_wdata <= s;
        @(posedge clk);
        seed_we <= 1'b0;
        mt_seed(s);
        seeds_used++;
    endtask

    task automatic test_directed();
        send_request(32'd0, 32'd9);
        send_request(32'h80000000, 32'h80000000);
        send_request(32'h7fffffff, 32'h7fffffff);
        send_request(32'd5, 32'd4);
        send_request(32'h7fffffff, 32'h80000000);
        send_request(32'h80000000, 32'h7fffffff);
        send_request(32'h80000000, 32'hfffffffe);
        send_request(32'h80000000, 32'hffffffff);
        send_request(32'h00000001, 32'h7fffffff);
        send_request(32'h00000000, 32'h7fffffff);
        send_request(32'hc0000000, 32'h3ffffffe);
        send_request(32'hffffffff, 32'h00000000);
        send_request(32'h7ffffffe, 32'h7fffffff);
        send_request(32'h80000000, 32'h80000001);
        send_request(32'd100, 32'd100);
        send_request(32'hffffff00, 32'h000000ff);
    endtask

    task automatic test_random(input int unsigned count);
        logic [31:0] lo;
        logic [31:0] hi;
        int sel;
        for (int unsigned n = 0; n < count; n++)
        begin
            lo = $urandom;
            sel = $urandom_range(0, 9);
            case (sel)
                0: hi = $urandom;
                1: hi = lo;
                2: hi = lo - $urandom_range(1, 1000);
                3: hi = lo + $urandom;
                default: hi = lo + ($urandom >> $urandom_range(1, 31));
            endcase
            send_request(lo, hi);
        end
    endtask

    task automatic test_seeds();
        write_seed(32'd0);
        test_random(100);
        write_seed(32'hffffffff);
        test_directed();
        test_random(100);
        write_seed($urandom);
        test_random(100);
    endtask

    // enough draws to cross a twist boundary
    task automatic test_twist_wrap();
        for (int n = 0; n < 650; n++)
            send_request($urandom & 32'h7fff, 32'h00ffffff);
    endtask

    initial
    begin
        mt_seed(brmt_pkg::SeedReset);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100);
        wait_drained();
        test_seeds();
        write_seed(brmt_pkg::SeedReset);
        test_twist_wrap();
        quiet = 1'b1;
        test_random(60);
        wait_drained();
        $display("%0d results checked over %0d seed settings, incl. twist wrap",
                 results_seen, seeds_used + 1);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/brmt_pkg.sv
rtl/brmt_front.sv
rtl/brmt_back.sv
rtl/bounded_random_mt19937.sv
test/tb_top.sv
